// File: sv/nss_pkg.sv
// Package for the nearest segment search block: widths, codes, state type
// and the request/status structs passed between the sequencer and its units.
// No dependencies.
`timescale 1ns / 1ps

package nss_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_W      = 24;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int PT_W         = 2 * COORD_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int OFS_W        = COORD_W + 1;
    localparam int MUL_W        = DIFF_W + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int LEN_W        = 2 * COORD_W + 2;
    localparam int QUO_W        = DIFF_W;
    localparam int NUM_W        = QUO_W + LEN_W;
    localparam int DEN_W        = LEN_W + 1;
    localparam int REM_W        = DEN_W;
    localparam int DCNT_W       = $clog2(QUO_W + 1);
    localparam int SQ_W         = COORD_W + 1;
    localparam int SQB_W        = $clog2(SQ_W);
    localparam int STEP_W       = 3;

    typedef enum logic
    {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_ADD,
        ST_RD,
        ST_LOAD,
        ST_MAC,
        ST_CLASS,
        ST_PMUL,
        ST_PDIV,
        ST_D2,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed
    {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_op_t;

    typedef struct packed
    {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed
    {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_stat_t;

endpackage

// File: sv/nss_if.sv
// Handshake channels of the nearest segment search block: request and
// response. Depends on nss_pkg for the field widths.
`timescale 1ns / 1ps

interface nss_req_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic signed [nss_pkg::COORD_W-1:0] start_x;
    logic signed [nss_pkg::COORD_W-1:0] start_y;
    logic signed [nss_pkg::COORD_W-1:0] coord_x;
    logic signed [nss_pkg::COORD_W-1:0] coord_y;
    logic                             exclude_valid;
    logic [5:0]                       exclude_index;

    modport source (output valid, op, start_x, start_y, coord_x, coord_y,
                    exclude_valid, exclude_index, input ready);
    modport sink   (input valid, op, start_x, start_y, coord_x, coord_y,
                    exclude_valid, exclude_index, output ready);
endinterface

interface nss_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             stored;
    logic signed [nss_pkg::COORD_W-1:0] end_x;
    logic signed [nss_pkg::COORD_W-1:0] end_y;
    logic                             found;
    logic [5:0]                       nearest_index;
    logic [nss_pkg::COORD_W-1:0]      distance;
    logic signed [nss_pkg::OFS_W-1:0] offset_x;
    logic signed [nss_pkg::OFS_W-1:0] offset_y;

    modport source (output valid, stored, end_x, end_y, found, nearest_index,
                    distance, offset_x, offset_y, input ready);
    modport sink   (input valid, stored, end_x, end_y, found, nearest_index,
                    distance, offset_x, offset_y, output ready);
endinterface

// File: sv/nss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/nss_mul.sv
// Shared signed multiplier with a registered product.
// Depends on nss_pkg.
`timescale 1ns / 1ps

module nss_mul (
    input  logic                          clk,
    input  nss_pkg::mul_op_t              op,
    output logic signed [nss_pkg::PROD_W-1:0] prod
);

    logic signed [nss_pkg::PROD_W-1:0] prod_reg;
    logic signed [nss_pkg::PROD_W-1:0] prod_next;

    assign prod_next = $signed(op.a) * $signed(op.b);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// File: sv/nss_div.sv
// Restoring divider, one quotient bit per cycle, for the projection step.
// Depends on nss_pkg for widths and the request/status structs.
`timescale 1ns / 1ps

module nss_div (
    input  logic               clk,
    input  logic               rst_n,
    input  nss_pkg::div_req_t  req,
    output nss_pkg::div_stat_t stat
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [nss_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic [nss_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [nss_pkg::QUO_W-1:0]   lo_reg, lo_next;
    logic [nss_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [nss_pkg::QUO_W-1:0]   quot_reg, quot_next;
    logic [nss_pkg::REM_W:0]     trial;
    logic                        qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, lo_reg[nss_pkg::QUO_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = nss_pkg::DCNT_W'(nss_pkg::QUO_W);
            // the top bits are already below the divisor: quotient fits QUO_W
            rem_next  = nss_pkg::REM_W'(req.num[nss_pkg::NUM_W-1:nss_pkg::QUO_W]);
            lo_next   = req.num[nss_pkg::QUO_W-1:0];
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? nss_pkg::REM_W'(trial - {1'b0, den_reg})
                             : trial[nss_pkg::REM_W-1:0];
            lo_next   = {lo_reg[nss_pkg::QUO_W-2:0], 1'b0};
            quot_next = {quot_reg[nss_pkg::QUO_W-2:0], qbit};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == nss_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

// File: sv/nearest_segment_search_top.sv
// Nearest segment search: segment table, sequencer and output register.
// Depends on nss_pkg, nss_if, nss_ram, nss_mul and nss_div.
`timescale 1ns / 1ps

// An add beat stores the segment if the table has room and reports whether
// it did; a query beat walks the segment table: an excluded segment is skipped,
// a segment whose closest point is an end point needs no division, and one
// whose closest point is interior runs two projection passes (25 quotient bits
// each) on the shared divider. A query that finds something then takes the
// square root one result bit at a time on the shared multiplier, and every
// query ends in the output step. The request side is not ready while a beat
// is in progress; a finished result waits in the output register until it is
// taken, and the sequencer stalls in its add or output step while that
// register is still full.
module nearest_segment_search_top (
    input  logic      clk,
    input  logic      rst_n,
    nss_req_if.sink   req,
    nss_rsp_if.source rsp
);

    localparam int CW = nss_pkg::COORD_W;
    localparam int DW = nss_pkg::DIFF_W;
    localparam int PW = nss_pkg::PROD_W;
    localparam int OW = nss_pkg::OFS_W;

    nss_pkg::state_t              state_reg, state_next;
    logic [nss_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [nss_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [nss_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         comp_reg, comp_next;
    logic                         found_reg, found_next;
    logic                         ovalid_reg, ovalid_next;

    logic signed [CW-1:0]         sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CW-1:0]         bx_reg, bx_next, by_reg, by_next;
    logic signed [CW-1:0]         cx_reg, cx_next, cy_reg, cy_next;
    logic                         exv_reg, exv_next;
    logic [nss_pkg::IDX_W-1:0]    exi_reg, exi_next;
    logic signed [DW-1:0]         dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DW-1:0]         ex_reg, ex_next, ey_reg, ey_next;
    logic signed [PW-1:0]         dot_reg, dot_next, len_reg, len_next;
    logic [nss_pkg::NUM_W-1:0]    nacc_reg, nacc_next;
    logic signed [OW-1:0]         ox_reg, ox_next, oy_reg, oy_next;
    logic signed [PW-1:0]         d2_reg, d2_next;
    logic [PW-1:0]                best_reg, best_next;
    logic [nss_pkg::IDX_W-1:0]    bidx_reg, bidx_next;
    logic signed [OW-1:0]         box_reg, box_next, boy_reg, boy_next;
    logic [nss_pkg::SQ_W-1:0]     res_reg, res_next;
    logic [nss_pkg::SQB_W-1:0]    bit_reg, bit_next;

    logic                         o_stored_reg, o_stored_next;
    logic signed [CW-1:0]         o_ex_reg, o_ex_next, o_ey_reg, o_ey_next;
    logic                         o_found_reg, o_found_next;
    logic [nss_pkg::IDX_W-1:0]    o_idx_reg, o_idx_next;
    logic [CW-1:0]                o_dist_reg, o_dist_next;
    logic signed [OW-1:0]         o_ox_reg, o_ox_next, o_oy_reg, o_oy_next;

    logic                         ram_we;
    logic [nss_pkg::PT_W-1:0]     start_rd, end_rd;
    nss_pkg::mul_op_t             mop;
    logic signed [PW-1:0]         prod;
    nss_pkg::div_req_t            dreq;
    nss_pkg::div_stat_t           dstat;

    logic                         ofree;
    logic signed [CW-1:0]         add_ex, add_ey;
    logic signed [DW-1:0]         ecomp;
    logic [DW-1:0]                emag;
    logic [nss_pkg::NUM_W-1:0]    nsum;
    logic signed [DW+1:0]         qs, ofs;
    logic signed [CW-1:0]         scomp, ccomp;
    logic signed [PW-1:0]         d2_sum;
    logic [nss_pkg::SQ_W-1:0]     cand;

    nss_ram #(.WIDTH(nss_pkg::PT_W), .DEPTH(nss_pkg::MAX_SEGMENTS)) u_start_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[nss_pkg::IDX_W-1:0]),
        .wdata ({sx_reg, sy_reg}),
        .raddr (idx_reg[nss_pkg::IDX_W-1:0]),
        .rdata (start_rd)
    );

    nss_ram #(.WIDTH(nss_pkg::PT_W), .DEPTH(nss_pkg::MAX_SEGMENTS)) u_end_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[nss_pkg::IDX_W-1:0]),
        .wdata ({add_ex, add_ey}),
        .raddr (idx_reg[nss_pkg::IDX_W-1:0]),
        .rdata (end_rd)
    );

    nss_mul u_mul (
        .clk  (clk),
        .op   (mop),
        .prod (prod)
    );

    nss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .stat  (dstat)
    );

    assign req.ready = (state_reg == nss_pkg::ST_IDLE);
    assign ofree     = !ovalid_reg || rsp.ready;
    assign add_ex    = sx_reg + cx_reg;
    assign add_ey    = sy_reg + cy_reg;
    assign ram_we    = (state_reg == nss_pkg::ST_ADD) && ofree &&
                       (cnt_reg < nss_pkg::CNT_W'(nss_pkg::MAX_SEGMENTS));

    assign ecomp  = comp_reg ? ey_reg : ex_reg;
    assign emag   = ecomp[DW-1] ? DW'(-ecomp) : DW'(ecomp);
    assign scomp  = comp_reg ? sy_reg : sx_reg;
    assign ccomp  = comp_reg ? cy_reg : cx_reg;
    assign qs     = ecomp[DW-1] ? -$signed({2'b00, dstat.quot})
                                : $signed({2'b00, dstat.quot});
    assign ofs    = (DW+2)'(scomp) + qs - (DW+2)'(ccomp);
    assign nsum   = nacc_reg + nss_pkg::NUM_W'(prod[nss_pkg::LEN_W-1:0]);
    assign d2_sum = d2_reg + prod;
    assign cand   = res_reg | (nss_pkg::SQ_W'(1) << bit_reg);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        comp_next    = comp_reg;
        found_next   = found_reg;
        ovalid_next  = ovalid_reg;
        sx_next = sx_reg;  sy_next = sy_reg;
        bx_next = bx_reg;  by_next = by_reg;
        cx_next = cx_reg;  cy_next = cy_reg;
        exv_next = exv_reg; exi_next = exi_reg;
        dx_next = dx_reg;  dy_next = dy_reg;
        ex_next = ex_reg;  ey_next = ey_reg;
        dot_next = dot_reg; len_next = len_reg;
        nacc_next = nacc_reg;
        ox_next = ox_reg;  oy_next = oy_reg;
        d2_next = d2_reg;  best_next = best_reg;
        bidx_next = bidx_reg;
        box_next = box_reg; boy_next = boy_reg;
        res_next = res_reg; bit_next = bit_reg;
        o_stored_next = o_stored_reg;
        o_ex_next = o_ex_reg; o_ey_next = o_ey_reg;
        o_found_next = o_found_reg; o_idx_next = o_idx_reg;
        o_dist_next = o_dist_reg;
        o_ox_next = o_ox_reg; o_oy_next = o_oy_reg;
        mop.a = '0;
        mop.b = '0;
        dreq.start = 1'b0;
        dreq.num   = {nsum[nss_pkg::NUM_W-2:0], 1'b0} +
                     nss_pkg::NUM_W'(len_reg[nss_pkg::LEN_W-1:0]);
        dreq.den   = {len_reg[nss_pkg::LEN_W-1:0], 1'b0};

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            nss_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    sx_next  = req.start_x;
                    sy_next  = req.start_y;
                    cx_next  = req.coord_x;
                    cy_next  = req.coord_y;
                    exv_next = req.exclude_valid;
                    exi_next = req.exclude_index;
                    idx_next = '0;
                    found_next = 1'b0;
                    state_next = (req.op == nss_pkg::OP_ADD) ? nss_pkg::ST_ADD
                                                             : nss_pkg::ST_RD;
                end
            end
            nss_pkg::ST_ADD:
            begin
                if (ofree)
                begin
                    o_stored_next = ram_we;
                    o_ex_next = add_ex;  o_ey_next = add_ey;
                    o_found_next = 1'b0; o_idx_next = '0; o_dist_next = '0;
                    o_ox_next = '0;      o_oy_next = '0;
                    ovalid_next = 1'b1;
                    if (ram_we)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = nss_pkg::ST_IDLE;
                end
            end
            nss_pkg::ST_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    res_next  = '0;
                    bit_next  = nss_pkg::SQB_W'(nss_pkg::SQ_W - 1);
                    step_next = '0;
                    state_next = found_reg ? nss_pkg::ST_SQRT : nss_pkg::ST_OUT;
                end
                else if (exv_reg && idx_reg[nss_pkg::IDX_W-1:0] == exi_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = nss_pkg::ST_LOAD;
                end
            end
            nss_pkg::ST_LOAD:
            begin
                sx_next = start_rd[nss_pkg::PT_W-1:CW];
                sy_next = start_rd[CW-1:0];
                bx_next = end_rd[nss_pkg::PT_W-1:CW];
                by_next = end_rd[CW-1:0];
                dx_next = DW'(cx_reg) - DW'($signed(start_rd[nss_pkg::PT_W-1:CW]));
                dy_next = DW'(cy_reg) - DW'($signed(start_rd[CW-1:0]));
                ex_next = DW'($signed(end_rd[nss_pkg::PT_W-1:CW])) -
                          DW'($signed(start_rd[nss_pkg::PT_W-1:CW]));
                ey_next = DW'($signed(end_rd[CW-1:0])) - DW'($signed(start_rd[CW-1:0]));
                step_next  = '0;
                state_next = nss_pkg::ST_MAC;
            end
            nss_pkg::ST_MAC:
            begin
                // issue one product a cycle, fold in the one from the cycle before
                case (step_reg)
                    3'd0:    begin mop.a = nss_pkg::MUL_W'(dx_reg); mop.b = nss_pkg::MUL_W'(ex_reg); end
                    3'd1:    begin mop.a = nss_pkg::MUL_W'(dy_reg); mop.b = nss_pkg::MUL_W'(ey_reg); end
                    3'd2:    begin mop.a = nss_pkg::MUL_W'(ex_reg); mop.b = nss_pkg::MUL_W'(ex_reg); end
                    3'd3:    begin mop.a = nss_pkg::MUL_W'(ey_reg); mop.b = nss_pkg::MUL_W'(ey_reg); end
                    default: begin mop.a = '0; mop.b = '0; end
                endcase
                case (step_reg)
                    3'd1:    dot_next = prod;
                    3'd2:    dot_next = dot_reg + prod;
                    3'd3:    len_next = prod;
                    3'd4:    len_next = len_reg + prod;
                    default: dot_next = dot_reg;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4)
                begin
                    state_next = nss_pkg::ST_CLASS;
                end
            end
            nss_pkg::ST_CLASS:
            begin
                step_next = '0;
                comp_next = 1'b0;
                if (dot_reg <= 0)
                begin
                    ox_next = -dx_reg;
                    oy_next = -dy_reg;
                    state_next = nss_pkg::ST_D2;
                end
                else if (dot_reg >= len_reg)
                begin
                    ox_next = OW'(bx_reg) - OW'(cx_reg);
                    oy_next = OW'(by_reg) - OW'(cy_reg);
                    state_next = nss_pkg::ST_D2;
                end
                else
                begin
                    state_next = nss_pkg::ST_PMUL;
                end
            end
            nss_pkg::ST_PMUL:
            begin
                // |e| * dot in two halves of the dot product
                mop.a = nss_pkg::MUL_W'(emag);
                mop.b = (step_reg == 3'd0)
                        ? nss_pkg::MUL_W'(dot_reg[2*nss_pkg::QUO_W-1:nss_pkg::QUO_W])
                        : nss_pkg::MUL_W'(dot_reg[nss_pkg::QUO_W-1:0]);
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd1)
                begin
                    nacc_next = {prod[nss_pkg::LEN_W-1:0], {nss_pkg::QUO_W{1'b0}}};
                end
                if (step_reg == 3'd2)
                begin
                    dreq.start = 1'b1;
                    state_next = nss_pkg::ST_PDIV;
                end
            end
            nss_pkg::ST_PDIV:
            begin
                if (dstat.done)
                begin
                    step_next = '0;
                    if (!comp_reg)
                    begin
                        ox_next = ofs[OW-1:0];
                        comp_next = 1'b1;
                        state_next = nss_pkg::ST_PMUL;
                    end
                    else
                    begin
                        oy_next = ofs[OW-1:0];
                        state_next = nss_pkg::ST_D2;
                    end
                end
            end
            nss_pkg::ST_D2:
            begin
                mop.a = (step_reg == 3'd0) ? nss_pkg::MUL_W'(ox_reg) : nss_pkg::MUL_W'(oy_reg);
                mop.b = mop.a;
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd1)
                begin
                    d2_next = prod;
                end
                if (step_reg == 3'd2)
                begin
                    if (!found_reg || $unsigned(d2_sum) < best_reg)
                    begin
                        found_next = 1'b1;
                        best_next  = $unsigned(d2_sum);
                        bidx_next  = idx_reg[nss_pkg::IDX_W-1:0];
                        box_next   = ox_reg;
                        boy_next   = oy_reg;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = nss_pkg::ST_RD;
                end
            end
            nss_pkg::ST_SQRT:
            begin
                mop.a = nss_pkg::MUL_W'(cand);
                mop.b = nss_pkg::MUL_W'(cand);
                if (step_reg == 3'd0)
                begin
                    step_next = 3'd1;
                end
                else
                begin
                    step_next = '0;
                    if (best_reg >= $unsigned(prod))
                    begin
                        res_next = cand;
                    end
                    if (bit_reg == '0)
                    begin
                        state_next = nss_pkg::ST_OUT;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                    end
                end
            end
            nss_pkg::ST_OUT:
            begin
                if (ofree)
                begin
                    o_stored_next = 1'b0;
                    o_ex_next = '0;  o_ey_next = '0;
                    o_found_next = found_reg;
                    o_idx_next  = found_reg ? bidx_reg : '0;
                    o_dist_next = !found_reg ? '0
                                : (res_reg[nss_pkg::SQ_W-1] ? '1 : res_reg[CW-1:0]);
                    o_ox_next = found_reg ? box_reg : '0;
                    o_oy_next = found_reg ? boy_reg : '0;
                    ovalid_next = 1'b1;
                    state_next  = nss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nss_pkg::ST_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            step_reg   <= '0;
            comp_reg   <= 1'b0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            step_reg   <= step_next;
            comp_reg   <= comp_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;  sy_reg <= sy_next;
        bx_reg <= bx_next;  by_reg <= by_next;
        cx_reg <= cx_next;  cy_reg <= cy_next;
        exv_reg <= exv_next; exi_reg <= exi_next;
        dx_reg <= dx_next;  dy_reg <= dy_next;
        ex_reg <= ex_next;  ey_reg <= ey_next;
        dot_reg <= dot_next; len_reg <= len_next;
        nacc_reg <= nacc_next;
        ox_reg <= ox_next;  oy_reg <= oy_next;
        d2_reg <= d2_next;  best_reg <= best_next;
        bidx_reg <= bidx_next;
        box_reg <= box_next; boy_reg <= boy_next;
        res_reg <= res_next; bit_reg <= bit_next;
        o_stored_reg <= o_stored_next;
        o_ex_reg <= o_ex_next; o_ey_reg <= o_ey_next;
        o_found_reg <= o_found_next; o_idx_reg <= o_idx_next;
        o_dist_reg <= o_dist_next;
        o_ox_reg <= o_ox_next; o_oy_reg <= o_oy_next;
    end

    assign rsp.valid         = ovalid_reg;
    assign rsp.stored        = o_stored_reg;
    assign rsp.end_x         = o_ex_reg;
    assign rsp.end_y         = o_ey_reg;
    assign rsp.found         = o_found_reg;
    assign rsp.nearest_index = o_idx_reg;
    assign rsp.distance      = o_dist_reg;
    assign rsp.offset_x      = o_ox_reg;
    assign rsp.offset_y      = o_oy_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= nss_pkg::CNT_W'(nss_pkg::MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_div_interior: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> (dot_reg > 0 && dot_reg < len_reg))
        else $error("division started outside the segment interior");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.done |-> state_reg == nss_pkg::ST_PDIV)
        else $error("divider finished while the sequencer was elsewhere");

    a_best_index: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> nss_pkg::CNT_W'(bidx_reg) < cnt_reg)
        else $error("best index outside the filled table");

    a_add_path: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == nss_pkg::OP_ADD)
        |=> state_reg == nss_pkg::ST_ADD)
        else $error("add beat did not reach the store step");

endmodule
